[hw/rtl/kls_pkg.sv]
// Shared types, constants and byte classifiers for the keyword lexer stream.
// Depends on nothing; used by kls_step and keyword_lexer_stream.
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

    // Counter and field widths
    localparam int unsigned LINE_W     = 20;
    localparam int unsigned OFF_W      = 24;
    localparam int unsigned KIND_W     = 5;
    localparam int unsigned KW_MAX_LEN = 10;
    localparam int unsigned KW_COUNT   = 12;
    localparam int unsigned IDLEN_W    = $clog2(KW_MAX_LEN + 2);
    localparam int unsigned KW_IDX_W   = $clog2(KW_MAX_LEN);

    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [OFF_W-1:0]  OFF_MAX  = '1;

    // Scanner modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_DRAIN  = 3'd4;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
    localparam logic [KIND_W-1:0] KIND_STRING = 5'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACK = 5'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACK = 5'd8;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd9;
    localparam logic [KIND_W-1:0] KIND_EQUAL  = 5'd10;
    localparam logic [KIND_W-1:0] KIND_KW0    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd23;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd24;

    // Keyword text, first character in the most significant used byte
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "template", "service", "stage", "use", "from", "run",
        "copy", "env", "expose", "cmd", "entrypoint", "workdir"
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{8, 7, 5, 3, 4, 3, 4, 3, 6, 3, 10, 7};

    typedef logic [KW_MAX_LEN-1:0][7:0] t_kw_buf;

    // Scanner state carried between items
    typedef struct packed {
        logic [2:0]         mode;
        logic [LINE_W-1:0]  line_no;
        logic [OFF_W-1:0]   offset;
        logic [OFF_W-1:0]   tstart;
        logic [IDLEN_W-1:0] idlen;
        t_kw_buf            kw_buf;
    } t_scan_state;

    localparam t_scan_state STATE_RESET = '{
        mode:    MODE_IDLE,
        line_no: LINE_W'(1),
        offset:  '0,
        tstart:  '0,
        idlen:   '0,
        kw_buf:  '0
    };

    // One result token
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line_no;
        logic [OFF_W-1:0]  start;
        logic [OFF_W-1:0]  length;
        logic              last;
    } t_token;

    typedef t_token [2:0] t_token_set;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Map a symbol byte to its kind; anything else maps to the error kind
    function automatic logic [KIND_W-1:0] sym_kind(input logic [7:0] c);
        logic [KIND_W-1:0] kind;
        case (c)
            8'h7B:   kind = KIND_LBRACE;
            8'h7D:   kind = KIND_RBRACE;
            8'h28:   kind = KIND_LPAREN;
            8'h29:   kind = KIND_RPAREN;
            8'h5B:   kind = KIND_LBRACK;
            8'h5D:   kind = KIND_RBRACK;
            8'h2C:   kind = KIND_COMMA;
            8'h3D:   kind = KIND_EQUAL;
            default: kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

    // Compare the buffered identifier against every keyword in parallel
    function automatic logic [KIND_W-1:0] kw_kind(input t_kw_buf kw_buf,
                                                  input logic [IDLEN_W-1:0] len);
        logic [KIND_W-1:0] kind;
        logic              hit;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == IDLEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < KW_LEN[k]) begin
                    if (kw_buf[i] != KW_TEXT[k][(KW_LEN[k] - 1 - i) * 8 +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                kind = KIND_KW0 + KIND_W'(k);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/kls_step.sv]
// Next-state and token logic for one source byte of the keyword lexer.
// Purely combinational; depends on kls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kls_step (
    input  kls_pkg::t_scan_state i_state,
    input  logic                 i_present,
    input  logic [7:0]           i_byte,
    input  logic                 i_eos,
    output kls_pkg::t_scan_state o_state,
    output kls_pkg::t_token_set  o_tokens,
    output logic [1:0]           o_count
);
    import kls_pkg::*;

    t_scan_state v;
    t_token_set  v_tok;
    logic [1:0]  v_n;
    logic        v_use;

    always_comb begin
        v     = i_state;
        v_tok = '0;
        v_n   = 2'd0;
        v_use = 1'b1;

        if (i_present) begin
            // Continue or close the token in progress
            case (v.mode)
                MODE_IDENT: begin
                    if (is_letter(i_byte) || is_digit(i_byte)) begin
                        if (v.idlen < IDLEN_W'(KW_MAX_LEN)) begin
                            v.kw_buf[v.idlen[KW_IDX_W-1:0]] = i_byte;
                        end
                        if (v.idlen <= IDLEN_W'(KW_MAX_LEN)) begin
                            v.idlen = v.idlen + IDLEN_W'(1);
                        end
                    end else begin
                        v_tok[v_n] = '{kw_kind(v.kw_buf, v.idlen), v.line_no, v.tstart,
                                       v.offset - v.tstart, 1'b0};
                        v_n    = v_n + 2'd1;
                        v.mode = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit(i_byte)) begin
                        v_tok[v_n] = '{KIND_NUMBER, v.line_no, v.tstart,
                                       v.offset - v.tstart, 1'b0};
                        v_n    = v_n + 2'd1;
                        v.mode = MODE_IDLE;
                    end
                end
                MODE_STRING: begin
                    if (i_byte == "\"") begin
                        v_tok[v_n] = '{KIND_STRING, v.line_no, v.tstart,
                                       v.offset - v.tstart, 1'b0};
                        v_n    = v_n + 2'd1;
                        v.mode = MODE_IDLE;
                        v_use  = 1'b0;
                    end else if (i_byte == 8'h0A) begin
                        if (v.line_no != LINE_MAX) begin
                            v.line_no = v.line_no + LINE_W'(1);
                        end
                    end
                end
                default: ;
            endcase

            // Start a new token or emit a single-byte one
            if (v.mode == MODE_IDLE && v_use) begin
                if (i_byte == " " || i_byte == 8'h09 || i_byte == 8'h0D) begin
                    v_use = 1'b0;
                end else if (i_byte == 8'h0A) begin
                    if (v.line_no != LINE_MAX) begin
                        v.line_no = v.line_no + LINE_W'(1);
                    end
                end else if (is_letter(i_byte)) begin
                    v.mode      = MODE_IDENT;
                    v.tstart    = v.offset;
                    v.kw_buf[0] = i_byte;
                    v.idlen     = IDLEN_W'(1);
                end else if (is_digit(i_byte)) begin
                    v.mode   = MODE_NUMBER;
                    v.tstart = v.offset;
                end else if (i_byte == "\"") begin
                    v.mode   = MODE_STRING;
                    v.tstart = (v.offset == OFF_MAX) ? v.offset : v.offset + OFF_W'(1);
                end else begin
                    v_tok[v_n] = '{sym_kind(i_byte), v.line_no, v.offset, OFF_W'(1),
                                   sym_kind(i_byte) == KIND_ERROR};
                    v_n = v_n + 2'd1;
                    if (sym_kind(i_byte) == KIND_ERROR) begin
                        v.mode = MODE_DRAIN;
                    end
                end
            end

            // Advance the saturating byte offset
            if (v.offset != OFF_MAX) begin
                v.offset = v.offset + OFF_W'(1);
            end
        end

        // End of source: flush, close the stream, return to reset
        if (i_eos) begin
            if (v.mode == MODE_IDENT) begin
                v_tok[v_n] = '{kw_kind(v.kw_buf, v.idlen), v.line_no, v.tstart,
                               v.offset - v.tstart, 1'b0};
                v_n = v_n + 2'd1;
            end else if (v.mode == MODE_NUMBER) begin
                v_tok[v_n] = '{KIND_NUMBER, v.line_no, v.tstart, v.offset - v.tstart, 1'b0};
                v_n = v_n + 2'd1;
            end else if (v.mode == MODE_STRING) begin
                v_tok[v_n] = '{KIND_STRING, v.line_no, v.tstart, v.offset - v.tstart, 1'b0};
                v_n = v_n + 2'd1;
            end
            if (v.mode != MODE_DRAIN) begin
                v_tok[v_n] = '{KIND_EOF, v.line_no, v.offset, OFF_W'(0), 1'b1};
                v_n = v_n + 2'd1;
            end
            v = STATE_RESET;
        end
    end

    assign o_state  = v;
    assign o_tokens = v_tok;
    assign o_count  = v_n;

endmodule

`default_nettype wire

[hw/rtl/keyword_lexer_stream.sv]
// Top level of the keyword lexer stream: input register, scanner state and
// a three-slot result buffer. Depends on kls_pkg and kls_step.
//
//   channel | direction | handshake                 | payload
//   input   | in        | i_in_valid / o_in_stall   | char_present, src_byte, end_of_source
//   output  | out       | o_out_valid / i_out_stall | token_kind .. last_token
//
// An accepted byte is registered, then scanned once its tokens have room; its
// tokens (zero to three) land in the result buffer together and, while the output
// is not stalled, leave one per cycle. With no output stall a byte giving at most
// one token sustains one byte per cycle; a byte giving more tokens holds the single
// output port until all are taken, so a following byte that also gives tokens waits
// in the input register. Reset is synchronous and active low and returns the scanner to
// line one, offset zero. Output stall backs up into the input register, then o_in_stall.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_char_present,
    input  logic [7:0]                     i_src_byte,
    input  logic                           i_end_of_source,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kls_pkg::KIND_W-1:0]     o_token_kind,
    output logic [kls_pkg::LINE_W-1:0]     o_line_number,
    output logic [kls_pkg::OFF_W-1:0]      o_start_offset,
    output logic [kls_pkg::OFF_W-1:0]      o_text_length,
    output logic                           o_last_token
);
    import kls_pkg::*;

    // Input register
    logic        r_in_valid;
    logic        r_present;
    logic [7:0]  r_byte;
    logic        r_eos;

    // Scanner state
    t_scan_state r_state;
    t_scan_state n_state;

    // Result buffer
    t_token      r_slot [3];
    logic [1:0]  r_head;
    logic [1:0]  r_cnt;

    t_token_set  w_tokens;
    logic [1:0]  w_count;
    logic        w_take;
    logic        w_adv;
    logic        w_accept;

    kls_step u_step (
        .i_state   (r_state),
        .i_present (r_present),
        .i_byte    (r_byte),
        .i_eos     (r_eos),
        .o_state   (n_state),
        .o_tokens  (w_tokens),
        .o_count   (w_count)
    );

    // Handshake: scan the held byte once its tokens have room
    assign w_take     = o_out_valid && !i_out_stall;
    assign w_adv      = r_in_valid &&
                        (w_count == 2'd0 || r_cnt == 2'd0 || (r_cnt == 2'd1 && w_take));
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Hold the incoming transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_present <= i_char_present;
            r_byte    <= i_src_byte;
            r_eos     <= i_end_of_source;
        end
    end

    // Advance the scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Load a token group or drop the token just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 2'd0;
            r_cnt  <= 2'd0;
        end else if (w_adv && w_count != 2'd0) begin
            r_head <= 2'd0;
            r_cnt  <= w_count;
        end else if (w_take) begin
            r_head <= r_head + 2'd1;
            r_cnt  <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_count != 2'd0) begin
            r_slot[0] <= w_tokens[0];
            r_slot[1] <= w_tokens[1];
            r_slot[2] <= w_tokens[2];
        end
    end

    // Present the head token
    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_token_kind   = r_slot[r_head].kind;
    assign o_line_number  = r_slot[r_head].line_no;
    assign o_start_offset = r_slot[r_head].start;
    assign o_text_length  = r_slot[r_head].length;
    assign o_last_token   = r_slot[r_head].last;

endmodule

`default_nettype wire
